// File: hw/rtl/spcg_pkg.sv
package spcg_pkg;

    // Command codes carried by the input transaction.
    typedef enum logic {
        CMD_CELL = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // Phase state of the current frame.
    typedef struct packed {
        logic [7:0] col_a;
        logic [7:0] col_b;
        logic [7:0] row_a;
        logic [7:0] row_b;
        logic [3:0] rot;
    } t_phases;

    // Per-frame phase steps. The B phases run backwards.
    localparam logic [7:0] COL_A_STEP = 8'd2;
    localparam logic [7:0] COL_B_STEP = 8'd3;
    localparam logic [7:0] ROW_A_STEP = 8'd3;
    localparam logic [7:0] ROW_B_STEP = 8'd5;
    localparam logic [3:0] ROT_STEP   = 4'd1;

    // Spatial frequencies of the four sine terms.
    localparam logic [7:0] COL_A_MUL = 8'd3;
    localparam logic [7:0] COL_B_MUL = 8'd7;
    localparam logic [7:0] ROW_A_MUL = 8'd4;
    localparam logic [7:0] ROW_B_MUL = 8'd9;

    // One period of a sine centered on 0x80.
    localparam logic [7:0] SINE_ROM [256] = '{
        8'h80, 8'h7d, 8'h7a, 8'h77, 8'h74, 8'h70, 8'h6d, 8'h6a, 8'h67, 8'h64, 8'h61, 8'h5e,
        8'h5b, 8'h58, 8'h55, 8'h52, 8'h4f, 8'h4d, 8'h4a, 8'h47, 8'h44, 8'h41, 8'h3f, 8'h3c,
        8'h39, 8'h37, 8'h34, 8'h32, 8'h2f, 8'h2d, 8'h2b, 8'h28, 8'h26, 8'h24, 8'h22, 8'h20,
        8'h1e, 8'h1c, 8'h1a, 8'h18, 8'h16, 8'h15, 8'h13, 8'h11, 8'h10, 8'h0f, 8'h0d, 8'h0c,
        8'h0b, 8'h0a, 8'h08, 8'h07, 8'h06, 8'h06, 8'h05, 8'h04, 8'h03, 8'h03, 8'h02, 8'h02,
        8'h02, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h02, 8'h02, 8'h02, 8'h03,
        8'h03, 8'h04, 8'h05, 8'h06, 8'h06, 8'h07, 8'h08, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0f,
        8'h10, 8'h11, 8'h13, 8'h15, 8'h16, 8'h18, 8'h1a, 8'h1c, 8'h1e, 8'h20, 8'h22, 8'h24,
        8'h26, 8'h28, 8'h2b, 8'h2d, 8'h2f, 8'h32, 8'h34, 8'h37, 8'h39, 8'h3c, 8'h3f, 8'h41,
        8'h44, 8'h47, 8'h4a, 8'h4d, 8'h4f, 8'h52, 8'h55, 8'h58, 8'h5b, 8'h5e, 8'h61, 8'h64,
        8'h67, 8'h6a, 8'h6d, 8'h70, 8'h74, 8'h77, 8'h7a, 8'h7d, 8'h80, 8'h83, 8'h86, 8'h89,
        8'h8c, 8'h90, 8'h93, 8'h96, 8'h99, 8'h9c, 8'h9f, 8'ha2, 8'ha5, 8'ha8, 8'hab, 8'hae,
        8'hb1, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbf, 8'hc1, 8'hc4, 8'hc7, 8'hc9, 8'hcc, 8'hce,
        8'hd1, 8'hd3, 8'hd5, 8'hd8, 8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
        8'hea, 8'heb, 8'hed, 8'hef, 8'hf0, 8'hf1, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf8, 8'hf9,
        8'hfa, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfd, 8'hfe, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfe, 8'hfe, 8'hfd, 8'hfd, 8'hfc, 8'hfb, 8'hfa,
        8'hfa, 8'hf9, 8'hf8, 8'hf6, 8'hf5, 8'hf4, 8'hf3, 8'hf1, 8'hf0, 8'hef, 8'hed, 8'heb,
        8'hea, 8'he8, 8'he6, 8'he4, 8'he2, 8'he0, 8'hde, 8'hdc, 8'hda, 8'hd8, 8'hd5, 8'hd3,
        8'hd1, 8'hce, 8'hcc, 8'hc9, 8'hc7, 8'hc4, 8'hc1, 8'hbf, 8'hbc, 8'hb9, 8'hb6, 8'hb3,
        8'hb1, 8'hae, 8'hab, 8'ha8, 8'ha5, 8'ha2, 8'h9f, 8'h9c, 8'h99, 8'h96, 8'h93, 8'h90,
        8'h8c, 8'h89, 8'h86, 8'h83
    };

endpackage

// File: hw/rtl/spcg_phase.sv
module spcg_phase import spcg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tick,
    output t_phases o_phases
);

    t_phases r_phases;
    t_phases n_phases;

    always_comb begin
        n_phases = r_phases;
        if (i_tick) begin
            n_phases.col_a = r_phases.col_a + COL_A_STEP;
            n_phases.col_b = r_phases.col_b - COL_B_STEP;
            n_phases.row_a = r_phases.row_a + ROW_A_STEP;
            n_phases.row_b = r_phases.row_b - ROW_B_STEP;
            n_phases.rot   = r_phases.rot + ROT_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phases <= '0;
        end else begin
            r_phases <= n_phases;
        end
    end

    assign o_phases = r_phases;

endmodule

// File: hw/rtl/spcg_cell_calc.sv
module spcg_cell_calc import spcg_pkg::*; (
    input  t_phases    i_phases,
    input  logic [7:0] i_column,
    input  logic [7:0] i_row,
    output logic [7:0] o_char_index
);

    logic [7:0] addr_col_a;
    logic [7:0] addr_col_b;
    logic [7:0] addr_row_a;
    logic [7:0] addr_row_b;
    logic [7:0] x_sum;
    logic [7:0] y_sum;

    // Products by small constants reduce to a shift and an add or two.
    assign addr_col_a = i_phases.col_a + 8'(i_column * COL_A_MUL);
    assign addr_col_b = i_phases.col_b + 8'(i_column * COL_B_MUL);
    assign addr_row_a = i_phases.row_a + 8'(i_row * ROW_A_MUL);
    assign addr_row_b = i_phases.row_b + 8'(i_row * ROW_B_MUL);

    assign x_sum = SINE_ROM[addr_col_a] + SINE_ROM[addr_col_b];
    assign y_sum = SINE_ROM[addr_row_a] + SINE_ROM[addr_row_b];

    assign o_char_index = x_sum + y_sum;

endmodule

// File: hw/rtl/sine_plasma_cell_generator_top.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_command, i_column, i_row
// output    out        o_out_valid / i_out_stall o_char_index, o_color_index,
//                                                o_palette_rotation
//
// One transaction per clock is taken when nothing stalls. An accepted cell sits in
// the input register while the sine lookups and adds feed the result register,
// which presents the cell result. A frame tick gives no result and advances the
// phases as it leaves, so only later cells see them.
// Reset (synchronous, active low) clears both valid flags and all phases.
// o_in_stall rises only while a cell waits in the input register behind a stalled result.
module sine_plasma_cell_generator_top import spcg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_column,
    input  logic [7:0] i_row,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_index,
    output logic [3:0] o_color_index,
    output logic [3:0] o_palette_rotation
);

    // Input register.
    logic       r_s1_valid;
    t_cmd       r_s1_cmd;
    logic [7:0] r_s1_column;
    logic [7:0] r_s1_row;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic [3:0] r_out_rot;

    logic       out_free;
    logic       s1_move;
    logic       s1_is_tick;
    logic       in_accept;
    logic [7:0] calc_char;
    t_phases    phases;

    // The result register can take a new value when empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_is_tick = (r_s1_cmd == CMD_TICK);
    // A tick never needs the result register, so it always moves on.
    assign s1_move    = r_s1_valid && (s1_is_tick || out_free);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd    <= t_cmd'(i_command);
            r_s1_column <= i_column;
            r_s1_row    <= i_row;
        end
    end

    spcg_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (s1_move && s1_is_tick),
        .o_phases (phases)
    );

    spcg_cell_calc u_calc (
        .i_phases     (phases),
        .i_column     (r_s1_column),
        .i_row        (r_s1_row),
        .o_char_index (calc_char)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_move && !s1_is_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_move && !s1_is_tick) begin
            r_out_char <= calc_char;
            r_out_rot  <= phases.rot;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_char_index       = r_out_char;
    assign o_color_index      = r_out_char[7:4];
    assign o_palette_rotation = r_out_rot;

endmodule

// File: hw/rtl/spcg_checker.sv
module spcg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_command,
    input logic [7:0] i_column,
    input logic [7:0] i_row,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_char_index,
    input logic [3:0] o_color_index,
    input logic [3:0] o_palette_rotation
);

    // A stalled input transaction stays offered with its payload unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_command)
            && $stable(i_column) && $stable(i_row)))
        else $error("input transaction changed while stalled");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_char_index)
            && $stable(o_palette_rotation)))
        else $error("result changed while stalled");

    // The color is always the upper nibble of the character.
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_color_index == o_char_index[7:4]))
        else $error("color index does not match character");

    // With the result register empty, the input side never stalls.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind sine_plasma_cell_generator_top spcg_checker u_spcg_checker (.*);
